/* rtl/core/spt_pkg.sv */
// Shared constants for the stereo point triangulation unit.
// No dependencies; used by spt_mul, spt_div and the triangulation unit.
package spt_pkg;

  // Default coefficient width and fixed field widths.
  localparam int COEF_WIDTH_DEF = 48;
  localparam int NCOEF          = 24;
  localparam int COORD_W        = 16;
  localparam int OUT_W          = 32;
  localparam int IDX_W          = 5;

  // Multiplier limb width and the fixed part of its latency.
  localparam int LIMB_W    = 32;
  localparam int MUL_FIXED = 3;

  // Divider: quotient bits, pre-shift of the numerator and latency.
  localparam int DIV_STEPS = 40;
  localparam int DIV_PRE   = 9;
  localparam int DIV_LAT   = DIV_STEPS + 3;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TRI  = 1'b1;

  // Saturation limits of a coordinate.
  localparam logic [OUT_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

/* rtl/core/spt_dly.sv */
// Fixed-length delay line used to align operands between pipeline levels.
// Depends on nothing.
module spt_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:N-1];

  // Shift one stage per cycle.
  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

/* rtl/core/spt_mul.sv */
// Pipelined signed multiplier built from 32x32 limb products, one limb of a per stage.
// Depends on spt_pkg.
module spt_mul #(
  parameter int AW = 17,
  parameter int BW = 48
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW  = spt_pkg::LIMB_W;
  localparam int NA  = (AW + LW - 1) / LW;
  localparam int NB  = (BW + LW - 1) / LW;
  localparam int ACW = (NA + NB) * LW;
  localparam int RWD = (NB + 1) * LW;
  localparam int PW  = AW + BW;

  logic signed [NA*LW-1:0] a_ext;
  logic signed [NB*LW-1:0] b_ext;
  logic [NA*LW-1:0]        ma   [0:NA-1];
  logic [NB*LW-1:0]        mb   [0:NA-1];
  logic                    sg   [0:NA+1];
  logic [2*LW-1:0]         prod [1:NA][0:NB-1];
  logic [RWD-1:0]          lo   [1:NA];
  logic [RWD-1:0]          hi   [1:NA];
  logic [ACW-1:0]          acc  [1:NA+1];

  assign a_ext = (NA*LW)'(a);
  assign b_ext = (NB*LW)'(b);

  // Stage zero: magnitudes and product sign.
  always_ff @(posedge clk) begin
    ma[0] <= a[AW-1] ? -a_ext : a_ext;
    mb[0] <= b[BW-1] ? -b_ext : b_ext;
    sg[0] <= a[AW-1] ^ b[BW-1];
  end

  // One limb of a against every limb of b per stage; the previous row is added in.
  for (genvar k = 1; k <= NA; k++) begin : g_stage
    always_comb begin
      lo[k] = '0;
      hi[k] = '0;
      for (int j = 0; j < NB; j++) begin
        lo[k][LW*j +: LW]     = prod[k][j][LW-1:0];
        hi[k][LW*(j+1) +: LW] = prod[k][j][2*LW-1:LW];
      end
    end

    always_ff @(posedge clk) begin
      for (int j = 0; j < NB; j++) begin
        prod[k][j] <= ma[k-1][LW*(k-1) +: LW] * mb[k-1][LW*j +: LW];
      end
      sg[k] <= sg[k-1];
    end

    if (k < NA) begin : g_pass
      always_ff @(posedge clk) begin
        ma[k] <= ma[k-1];
        mb[k] <= mb[k-1];
      end
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        acc[1] <= '0;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        acc[k] <= acc[k-1] + ((ACW'(lo[k-1]) + ACW'(hi[k-1])) << (LW*(k-2)));
      end
    end
  end

  // Last row, then the sign.
  always_ff @(posedge clk) begin
    acc[NA+1] <= acc[NA] + ((ACW'(lo[NA]) + ACW'(hi[NA])) << (LW*(NA-1)));
    sg[NA+1]  <= sg[NA];
    p         <= sg[NA+1] ? PW'(-acc[NA+1]) : PW'(acc[NA+1]);
  end

endmodule

/* rtl/core/spt_div.sv */
// Pipelined restoring divider: round(num*256/den), ties away from zero, saturated to 32 bits.
// Depends on spt_pkg. One quotient bit per stage.
module spt_div #(
  parameter int DW = 405
) (
  input  logic                           clk,
  input  logic signed [DW-1:0]           num,
  input  logic signed [DW-1:0]           den,
  output logic [spt_pkg::OUT_W-1:0]      q
);

  localparam int NS = spt_pkg::DIV_STEPS;
  localparam int RW = DW + NS + 1;

  logic [DW-1:0] mn;
  logic [DW-1:0] md;
  logic          sa;
  logic [RW-1:0] rem [0:NS-1];
  logic [DW-1:0] dd  [0:NS-1];
  logic [NS-1:0] t   [0:NS];
  logic          sg  [0:NS];
  logic          sat [0:NS];
  logic [NS:0]   qr;

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    mn <= num[DW-1] ? DW'(-num) : DW'(num);
    md <= den[DW-1] ? DW'(-den) : DW'(den);
    sa <= num[DW-1] ^ den[DW-1];
  end

  // Scale the numerator and check for a quotient beyond the range.
  always_ff @(posedge clk) begin
    rem[0] <= RW'(mn) << spt_pkg::DIV_PRE;
    dd[0]  <= md;
    t[0]   <= '0;
    sg[0]  <= sa;
    sat[0] <= (RW'(mn) << spt_pkg::DIV_PRE) >= (RW'(md) << NS);
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= NS; s++) begin : g_step
    localparam int K = NS - s;
    logic [RW-1:0] dk;
    logic          ge;

    assign dk = RW'(dd[s-1]) << K;
    assign ge = rem[s-1] >= dk;

    always_ff @(posedge clk) begin
      t[s]   <= ge ? (t[s-1] | (NS'(1) << K)) : t[s-1];
      sg[s]  <= sg[s-1];
      sat[s] <= sat[s-1];
    end

    if (s < NS) begin : g_rem
      always_ff @(posedge clk) begin
        rem[s] <= ge ? (rem[s-1] - dk) : rem[s-1];
        dd[s]  <= dd[s-1];
      end
    end
  end

  // Round off the guard bit, saturate and apply the sign.
  assign qr = ({1'b0, t[NS]} + (NS+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (sat[NS]) begin
      q <= sg[NS] ? spt_pkg::Q_MIN : spt_pkg::Q_MAX;
    end else if (sg[NS]) begin
      q <= (qr >= (NS+1)'(spt_pkg::Q_MIN)) ? spt_pkg::Q_MIN : spt_pkg::OUT_W'(-qr);
    end else begin
      q <= (qr > (NS+1)'(spt_pkg::Q_MAX)) ? spt_pkg::Q_MAX : spt_pkg::OUT_W'(qr);
    end
  end

endmodule

/* rtl/core/stereo_point_triangulation_unit.sv */
// Stereo point triangulation: coefficient store, exact normal-equation datapath, dividers.
// Depends on spt_pkg, spt_mul, spt_dly and spt_div.
//
// Usage. A word is accepted at a rising edge with start high; busy is always low, so a
// word can be given every cycle. cmd = load writes coef_value into slot coef_index
// (0-11 left matrix row-major, 12-23 right; higher slots are ignored) and gives no
// result. cmd = triangulate takes u_left, v_left, u_right, v_right and yields one result
// word: x_mm, y_mm, z_mm and singular, valid for the single cycle that done is high.
// A load takes effect for a triangulate word accepted in the next cycle or later.
// From accept to done a word passes four levels of limb multipliers, each followed by a
// summing register, then the divider that makes one quotient bit a stage, and one
// output register.
// Throughput is one word per cycle. Results leave in the order words were accepted.
// The receiver cannot stall; it must take each result in the cycle it appears.
// Synchronous reset clears the coefficients to zero and drops every word in flight.
module stereo_point_triangulation_unit #(
  parameter int COEF_WIDTH = spt_pkg::COEF_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [spt_pkg::IDX_W-1:0]   coef_index,
  input  logic signed [COEF_WIDTH-1:0] coef_value,
  input  logic [spt_pkg::COORD_W-1:0] u_left,
  input  logic [spt_pkg::COORD_W-1:0] v_left,
  input  logic [spt_pkg::COORD_W-1:0] u_right,
  input  logic [spt_pkg::COORD_W-1:0] v_right,
  output logic                        done,
  output logic signed [spt_pkg::OUT_W-1:0] x_mm,
  output logic signed [spt_pkg::OUT_W-1:0] y_mm,
  output logic signed [spt_pkg::OUT_W-1:0] z_mm,
  output logic                        singular
);

  localparam int CW = COEF_WIDTH;
  localparam int LW = spt_pkg::LIMB_W;
  localparam int WW = spt_pkg::COORD_W + 1;
  localparam int AW = CW + spt_pkg::COORD_W + 2;
  localparam int NW = 2 * AW + 2;
  localparam int MW = 2 * NW + 1;
  localparam int DW = NW + MW + 2;

  localparam int L1 = (WW + LW - 1) / LW + spt_pkg::MUL_FIXED;
  localparam int L2 = (AW + LW - 1) / LW + spt_pkg::MUL_FIXED;
  localparam int L3 = (NW + LW - 1) / LW + spt_pkg::MUL_FIXED;
  localparam int L4 = L3;
  localparam int LD = spt_pkg::DIV_LAT;

  localparam int SA    = L1 + 1;
  localparam int SN    = SA + L2 + 1;
  localparam int SC    = SN + L3 + 1;
  localparam int SD    = SC + L4 + 1;
  localparam int TOTAL = SD + LD + 1;

  // Cofactor operand tables over the upper triangle {n00,n01,n02,n11,n12,n22}.
  localparam int L3A [12] = '{3, 4, 4, 1, 1, 3, 0, 2, 1, 0, 0, 1};
  localparam int L3B [12] = '{5, 4, 2, 5, 4, 2, 5, 2, 2, 4, 3, 1};
  // Cofactor index of (row, column) of the symmetric adjugate.
  localparam int CIDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

  logic [CW-1:0]          coef [0:spt_pkg::NCOEF-1];
  logic                   acc_load;
  logic                   acc_tri;
  logic [TOTAL-1:0]       vld;
  logic [spt_pkg::COORD_W-1:0] crd [0:3];

  logic signed [WW+CW-1:0] p1   [0:3][0:3];
  logic [CW-1:0]           dc1  [0:3][0:3];
  logic signed [AW-1:0]    ab_q [0:3][0:3];

  logic signed [2*AW-1:0]  p2   [0:2][0:3][0:3];
  logic signed [NW-1:0]    nm_q [0:2][0:3];

  logic signed [NW-1:0]    nu   [0:5];
  logic signed [NW-1:0]    cv   [0:2];
  logic [NW-1:0]           nu_d [0:2];
  logic [NW-1:0]           cv_d [0:2];
  logic signed [2*NW-1:0]  p3   [0:11];
  logic signed [MW-1:0]    cof_q [0:5];

  logic signed [NW+MW-1:0] p4   [0:3][0:2];
  logic signed [DW-1:0]    dn_q [0:3];
  logic                    det_zero;
  logic                    sing_d;
  logic [spt_pkg::OUT_W-1:0] qd [0:2];

  assign busy     = 1'b0;
  assign acc_load = start && !busy && (cmd == spt_pkg::CMD_LOAD);
  assign acc_tri  = start && !busy && (cmd == spt_pkg::CMD_TRI);

  // Coefficient store; slots beyond the last are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spt_pkg::NCOEF; i++) begin
        coef[i] <= '0;
      end
    end else if (acc_load) begin
      for (int i = 0; i < spt_pkg::NCOEF; i++) begin
        if (coef_index == spt_pkg::IDX_W'(i)) begin
          coef[i] <= coef_value;
        end
      end
    end
  end

  // Valid bits travel alongside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL-2:0], acc_tri};
    end
  end

  assign crd[0] = u_left;
  assign crd[1] = v_left;
  assign crd[2] = u_right;
  assign crd[3] = v_right;

  // Level one: rows of A (columns 0-2) and b (column 3), all in Q.28.
  for (genvar r = 0; r < 4; r++) begin : g_row
    localparam int BASE = (r < 2) ? 0 : 12;
    localparam int ROW  = r % 2;
    for (genvar j = 0; j < 4; j++) begin : g_col
      localparam int MIDX = (j < 3) ? (BASE + 8 + j) : (BASE + 11);
      localparam int DIDX = BASE + ROW * 4 + j;

      spt_mul #(.AW(WW), .BW(CW)) u_mul (
        .clk (clk),
        .a   (signed'({1'b0, crd[r]})),
        .b   (signed'(coef[MIDX])),
        .p   (p1[r][j])
      );

      spt_dly #(.W(CW), .N(L1)) u_dly (
        .clk (clk),
        .d   (coef[DIDX]),
        .q   (dc1[r][j])
      );

      always_ff @(posedge clk) begin
        if (j < 3) begin
          ab_q[r][j] <= AW'(p1[r][j]) - (AW'(signed'(dc1[r][j])) <<< 4);
        end else begin
          ab_q[r][j] <= (AW'(signed'(dc1[r][j])) <<< 4) - AW'(p1[r][j]);
        end
      end
    end
  end

  // Level two: upper triangle of A^T A and the vector A^T b.
  for (genvar i = 0; i < 3; i++) begin : g_ni
    for (genvar j = 0; j < 4; j++) begin : g_nj
      if (j >= i) begin : g_upper
        for (genvar k = 0; k < 4; k++) begin : g_k
          spt_mul #(.AW(AW), .BW(AW)) u_mul (
            .clk (clk),
            .a   (ab_q[k][i]),
            .b   (ab_q[k][j]),
            .p   (p2[i][j][k])
          );
        end

        always_ff @(posedge clk) begin
          nm_q[i][j] <= NW'(p2[i][j][0]) + NW'(p2[i][j][1])
                      + NW'(p2[i][j][2]) + NW'(p2[i][j][3]);
        end
      end
    end
  end

  assign nu[0] = nm_q[0][0];
  assign nu[1] = nm_q[0][1];
  assign nu[2] = nm_q[0][2];
  assign nu[3] = nm_q[1][1];
  assign nu[4] = nm_q[1][2];
  assign nu[5] = nm_q[2][2];
  assign cv[0] = nm_q[0][3];
  assign cv[1] = nm_q[1][3];
  assign cv[2] = nm_q[2][3];

  // Level three: the six distinct cofactors of the symmetric matrix.
  for (genvar q = 0; q < 12; q++) begin : g_cm
    spt_mul #(.AW(NW), .BW(NW)) u_mul (
      .clk (clk),
      .a   (nu[L3A[q]]),
      .b   (nu[L3B[q]]),
      .p   (p3[q])
    );
  end

  for (genvar q = 0; q < 6; q++) begin : g_cof
    always_ff @(posedge clk) begin
      cof_q[q] <= MW'(p3[2*q]) - MW'(p3[2*q+1]);
    end
  end

  // First row and right side wait for the cofactors.
  for (genvar k = 0; k < 3; k++) begin : g_align
    spt_dly #(.W(NW), .N(L3 + 1)) u_dly_n (
      .clk (clk),
      .d   (nu[k]),
      .q   (nu_d[k])
    );

    spt_dly #(.W(NW), .N(L3 + 1)) u_dly_c (
      .clk (clk),
      .d   (cv[k]),
      .q   (cv_d[k])
    );
  end

  // Level four: determinant (group 0) and the three Cramer numerators.
  for (genvar g = 0; g < 4; g++) begin : g_dn
    localparam int COL = (g == 0) ? 0 : (g - 1);
    for (genvar k = 0; k < 3; k++) begin : g_k
      spt_mul #(.AW(NW), .BW(MW)) u_mul (
        .clk (clk),
        .a   ((g == 0) ? signed'(nu_d[k]) : signed'(cv_d[k])),
        .b   (cof_q[CIDX[k*3 + COL]]),
        .p   (p4[g][k])
      );
    end

    always_ff @(posedge clk) begin
      dn_q[g] <= DW'(p4[g][0]) + DW'(p4[g][1]) + DW'(p4[g][2]);
    end
  end

  assign det_zero = (dn_q[0] == '0);

  // Division of each numerator by the determinant.
  for (genvar i = 0; i < 3; i++) begin : g_div
    spt_div #(.DW(DW)) u_div (
      .clk (clk),
      .num (dn_q[i+1]),
      .den (dn_q[0]),
      .q   (qd[i])
    );
  end

  spt_dly #(.W(1), .N(LD)) u_dly_sing (
    .clk (clk),
    .d   (det_zero),
    .q   (sing_d)
  );

  // Result word; a singular system gives zero coordinates.
  always_ff @(posedge clk) begin
    x_mm     <= sing_d ? '0 : signed'(qd[0]);
    y_mm     <= sing_d ? '0 : signed'(qd[1]);
    z_mm     <= sing_d ? '0 : signed'(qd[2]);
    singular <= sing_d;
  end

  assign done = vld[TOTAL-1];

  // A singular result carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (x_mm == '0 && y_mm == '0 && z_mm == '0))
    else $error("singular result with nonzero coordinates");

  // A load into a valid slot is visible in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (acc_load && coef_index < spt_pkg::IDX_W'(spt_pkg::NCOEF))
      |=> (coef[$past(coef_index)] == $past(coef_value)))
    else $error("coefficient load lost");

  // A zero determinant in flight comes out as a singular result.
  assert property (@(posedge clk) disable iff (rst)
    (vld[SD-1] && det_zero) |-> ##(LD + 1) (done && singular))
    else $error("zero determinant not flagged");

endmodule
